// File: rtl/arpeggiator_note_walker_defines.svh
// Assertion macros used by the note walker datapath.
`ifndef ARPEGGIATOR_NOTE_WALKER_DEFINES_SVH
`define ARPEGGIATOR_NOTE_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define ANW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("anw: %m check failed");
`define ANW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("anw: %m check failed");
`else
`define ANW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ANW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/anw_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package anw_pkg;

   localparam int MAX_HELD_DEF = 16;
   localparam int PITCH_W      = 8;
   localparam int ORDER_W      = 32;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_REMOVE  = 2'd2;
   localparam logic [1:0] CMD_ADVANCE = 2'd3;

   localparam logic [3:0] MODE_ORDER     = 4'd0;
   localparam logic [3:0] MODE_UP        = 4'd1;
   localparam logic [3:0] MODE_DOWN      = 4'd2;
   localparam logic [3:0] MODE_UPDOWN    = 4'd3;
   localparam logic [3:0] MODE_DOWNUP    = 4'd4;
   localparam logic [3:0] MODE_UPANDDOWN = 4'd5;
   localparam logic [3:0] MODE_DOWNANDUP = 4'd6;
   localparam logic [3:0] MODE_CONVERGE  = 4'd7;
   localparam logic [3:0] MODE_DIVERGE   = 4'd8;
   localparam logic [3:0] MODE_RANDOM    = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_WALK_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_SPAN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVAL_LOCK = 2'd2;

   typedef struct packed {
      logic accept;
      logic decode;
      logic scan_rd;
      logic scan_ev;
      logic scan_end;
      logic shift_rd;
      logic shift_wr;
      logic commit;
      logic mod1_go;
      logic mod2_go;
      logic mod1_take;
      logic mod2_take;
      logic rk_i_rd;
      logic rk_i_ev;
      logic rk_j_rd;
      logic rk_j_ev;
      logic rk_chk;
      logic pick;
      logic out_rd;
      logic out_ev;
      logic respond;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] item_cmd;
      logic       total_zero;
      logic       full;
      logic       locked;
      logic       mode_order;
      logic       mode_random;
      logic       scan_last;
      logic       scan_hit;
      logic       shift_done;
      logic       rem_busy;
      logic       i_last;
      logic       j_last;
      logic       rank_hit;
      logic       out_free;
   } ctl_stat_type;

endpackage

// File: rtl/arpeggiator_note_walker.sv
// Arpeggiator note walker: held-note table and step picker.
//
// The req channel takes one command item at a time: restart the walk, add a
// note, remove a note or advance one step. Each item gives exactly one item
// on the rsp channel with the picked note (advance only), the octave offset
// and the number of held notes. The csr channel writes walk mode, octave
// span and removal lock; csr_ready is always high. Writes are meant to land
// while idle: the user must keep to that, the block itself does not enforce it.
// Each item walks the table with a registered read per entry visit and may
// use the remainder unit; one item is in work at a time.
// Reset empties the table, restarts the walk and sets walk mode to up.
// The result sits in an output register: the next req item is accepted
// while it waits, and a stalled rsp only holds the block at its final step.
module arpeggiator_note_walker #(
   parameter int MAX_HELD = anw_pkg::MAX_HELD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command[1:0], note_pitch[9:2], random_pick[17:10], zero fill
   input  logic [anw_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // note_valid[0], chosen_pitch[8:1], chosen_slot[12:9], octave_shift[16:13],
   // held_count[21:17], zero fill
   output logic [anw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [anw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [anw_pkg::CSR_DATA_W-1:0]    csr_data
);
   import anw_pkg::*;

   ctl_cmd_type  ctl;
   ctl_stat_type stat;

   assign csr_ready = 1'b1;

   anw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   anw_datapath #(.MAX_HELD(MAX_HELD)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

// File: rtl/anw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module anw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/anw_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
module anw_rem #(
   parameter int D_W = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [D_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [D_W-1:0] remainder
);
   localparam int CW = $clog2(D_W + 1);

   logic [D_W-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [D_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[D_W-1]};
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(D_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[D_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = D_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[D_W-1:0];
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;
endmodule

// File: rtl/anw_ctrl.sv
// Sequencer for the note walker: steps each command through table scans and picks.
module anw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  anw_pkg::ctl_stat_type stat,
   output anw_pkg::ctl_cmd_type  ctl
);
   import anw_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE      = 22'h000001,
      S_DECODE    = 22'h000002,
      S_SCAN_RD   = 22'h000004,
      S_SCAN_EV   = 22'h000008,
      S_SCAN_END  = 22'h000010,
      S_SHIFT_CHK = 22'h000020,
      S_SHIFT_RD  = 22'h000040,
      S_SHIFT_WR  = 22'h000080,
      S_COMMIT    = 22'h000100,
      S_MOD1_GO   = 22'h000200,
      S_MOD1_WAIT = 22'h000400,
      S_MOD2_GO   = 22'h000800,
      S_MOD2_WAIT = 22'h001000,
      S_RK_I_RD   = 22'h002000,
      S_RK_I_EV   = 22'h004000,
      S_RK_J_RD   = 22'h008000,
      S_RK_J_EV   = 22'h010000,
      S_RK_CHK    = 22'h020000,
      S_PICK      = 22'h040000,
      S_OUT_RD    = 22'h080000,
      S_OUT_EV    = 22'h100000,
      S_RESPOND   = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ctl.accept = req_tvalid;
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            ctl.decode = 1'b1;
            unique case (stat.item_cmd)
               CMD_RESTART: state_in = stat.total_zero ? S_RESPOND : S_SCAN_RD;
               CMD_ADD: begin
                  if (stat.full) state_in = S_RESPOND;
                  else if (stat.total_zero) state_in = S_SHIFT_CHK;
                  else state_in = S_SCAN_RD;
               end
               CMD_REMOVE: begin
                  state_in = (stat.locked || stat.total_zero) ? S_RESPOND : S_SCAN_RD;
               end
               default: state_in = stat.total_zero ? S_RESPOND : S_MOD1_GO;
            endcase
         end
         S_SCAN_RD: begin
            ctl.scan_rd = 1'b1;
            state_in    = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            ctl.scan_ev = 1'b1;
            state_in    = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
         end
         S_SCAN_END: begin
            ctl.scan_end = 1'b1;
            unique case (stat.item_cmd)
               CMD_ADD:    state_in = stat.scan_hit ? S_RESPOND : S_SHIFT_CHK;
               CMD_REMOVE: state_in = stat.scan_hit ? S_SHIFT_CHK : S_RESPOND;
               default:    state_in = S_RESPOND;
            endcase
         end
         S_SHIFT_CHK: state_in = stat.shift_done ? S_COMMIT : S_SHIFT_RD;
         S_SHIFT_RD: begin
            ctl.shift_rd = 1'b1;
            state_in     = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ctl.shift_wr = 1'b1;
            state_in     = S_SHIFT_CHK;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = S_RESPOND;
         end
         S_MOD1_GO: begin
            ctl.mod1_go = 1'b1;
            state_in    = S_MOD1_WAIT;
         end
         S_MOD1_WAIT: begin
            ctl.mod1_take = !stat.rem_busy;
            if (!stat.rem_busy) begin
               if (stat.mode_random) state_in = S_MOD2_GO;
               else if (stat.mode_order) state_in = S_RK_I_RD;
               else state_in = S_PICK;
            end
         end
         S_MOD2_GO: begin
            ctl.mod2_go = 1'b1;
            state_in    = S_MOD2_WAIT;
         end
         S_MOD2_WAIT: begin
            ctl.mod2_take = !stat.rem_busy;
            if (!stat.rem_busy) state_in = S_PICK;
         end
         S_RK_I_RD: begin
            ctl.rk_i_rd = 1'b1;
            state_in    = S_RK_I_EV;
         end
         S_RK_I_EV: begin
            ctl.rk_i_ev = 1'b1;
            state_in    = S_RK_J_RD;
         end
         S_RK_J_RD: begin
            ctl.rk_j_rd = 1'b1;
            state_in    = S_RK_J_EV;
         end
         S_RK_J_EV: begin
            ctl.rk_j_ev = 1'b1;
            state_in    = stat.j_last ? S_RK_CHK : S_RK_J_RD;
         end
         S_RK_CHK: begin
            ctl.rk_chk = 1'b1;
            state_in   = (stat.rank_hit || stat.i_last) ? S_PICK : S_RK_I_RD;
         end
         S_PICK: begin
            ctl.pick = 1'b1;
            state_in = S_OUT_RD;
         end
         S_OUT_RD: begin
            ctl.out_rd = 1'b1;
            state_in   = S_OUT_EV;
         end
         S_OUT_EV: begin
            ctl.out_ev = 1'b1;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            ctl.respond = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/anw_datapath.sv
// Note table, walk state, remainder unit and result register of the note walker.
`include "arpeggiator_note_walker_defines.svh"
module anw_datapath #(
   parameter int MAX_HELD = anw_pkg::MAX_HELD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  anw_pkg::ctl_cmd_type              ctl,
   output anw_pkg::ctl_stat_type             stat,
   input  logic [anw_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              csr_we,
   input  logic [anw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [anw_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [anw_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import anw_pkg::*;

   localparam int IDX_W = $clog2(MAX_HELD);
   localparam int CNT_W = $clog2(MAX_HELD + 1);
   localparam int SU    = $clog2(2 * MAX_HELD);
   localparam int WP_W  = SU + 1;
   localparam int SW    = SU + 2;
   localparam int D_W   = ($clog2(2 * MAX_HELD + 1) > 8) ? $clog2(2 * MAX_HELD + 1) : 8;
   localparam int ENT_W = ORDER_W + PITCH_W;
   localparam logic signed [SW-1:0] ONE_S = SW'(1);
   localparam logic signed [SW-1:0] TWO_S = SW'(2);

   // configuration
   logic [3:0]        mode_ff, mode_in;
   logic signed [4:0] span_ff, span_in;
   logic              lock_ff, lock_in;
   // item
   logic [1:0]               cmd_ff, cmd_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [7:0]               rnd_ff, rnd_in;
   // walk state
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [ORDER_W-1:0]     oc_ff, oc_in;
   logic signed [WP_W-1:0] wpos_ff, wpos_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic signed [3:0]      oct_ff, oct_in;
   logic signed [1:0]      head_ff, head_in;
   // work registers
   logic [CNT_W-1:0]   idx_ff, idx_in, jdx_ff, jdx_in, below_ff, below_in, pos_ff, pos_in;
   logic [ORDER_W-1:0] key_ff, key_in;
   logic               hit_ff, hit_in, posfound_ff, posfound_in;
   logic [SU-1:0]      s_ff, s_in;
   logic [IDX_W-1:0]   rmod_ff, rmod_in, rank_ff, rank_in;
   logic               vres_ff, vres_in;
   logic [PITCH_W-1:0] rpitch_ff, rpitch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory and remainder unit
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [ENT_W-1:0]      wr_data, rd_data;
   logic                  rem_start, rem_busy;
   logic [D_W-1:0]        rem_num, rem_den, rem_out;

   logic signed [PITCH_W-1:0] rd_pitch;
   logic [ORDER_W-1:0]        rd_order;
   logic [CNT_W-1:0]          total_m1, idx_m1, idx_p1, shift_addr;
   logic signed [WP_W:0]      wp1;
   logic [D_W-1:0]            n_d, mod1_den;
   logic signed [SW-1:0]      n_s, s_v, h_v, rank_s, rmod_s, below_s, slot_raw, slot_rev;
   logic signed [SW-1:0]      slot_c, s_new;
   logic signed [4:0]         sp_c, now_c, hd_c;
   logic                      both_c;
   logic [IDX_W+3:0]          slot_ext;
   logic [CNT_W+4:0]          count_ext;

   assign rd_pitch = signed'(rd_data[PITCH_W-1:0]);
   assign rd_order = rd_data[ENT_W-1:PITCH_W];
   assign total_m1 = total_ff - CNT_W'(1);
   assign idx_m1   = idx_ff - CNT_W'(1);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign shift_addr = (cmd_ff == CMD_ADD) ? idx_m1 : idx_p1;

   always_comb begin
      if (ctl.rk_j_rd) rd_addr = jdx_ff[IDX_W-1:0];
      else if (ctl.shift_rd) rd_addr = shift_addr[IDX_W-1:0];
      else if (ctl.out_rd) rd_addr = cur_ff;
      else rd_addr = idx_ff[IDX_W-1:0];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_data;
      if (ctl.shift_wr) begin
         wr_en = 1'b1;
      end else if (ctl.commit && cmd_ff == CMD_ADD) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[IDX_W-1:0];
         wr_data = {oc_ff + ORDER_W'(1), pitch_ff};
      end
   end

   anw_ram #(.WIDTH(ENT_W), .DEPTH(MAX_HELD)) u_notes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // remainder operands: walk position step, or random value against the note count
   assign wp1 = {wpos_ff[WP_W-1], wpos_ff} + (WP_W+1)'(1);
   assign n_d = D_W'(total_ff);
   always_comb begin
      case (mode_ff) inside
         MODE_UPDOWN, MODE_DOWNUP: begin
            mod1_den = (total_ff >= CNT_W'(2)) ? (n_d + n_d - D_W'(2)) : D_W'(1);
         end
         MODE_UPANDDOWN, MODE_DOWNANDUP: mod1_den = n_d + n_d;
         default: mod1_den = n_d;
      endcase
   end
   assign rem_start = ctl.mod1_go || ctl.mod2_go;
   assign rem_num   = ctl.mod2_go ? D_W'(rnd_ff) : D_W'(wp1);
   assign rem_den   = ctl.mod2_go ? n_d : mod1_den;

   anw_rem #(.D_W(D_W)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_num),
      .divisor   (rem_den),
      .busy      (rem_busy),
      .remainder (rem_out)
   );

   // octave walk step, taken when the walk position comes back to zero
   always_comb begin
      sp_c   = span_ff;
      both_c = 1'b0;
      if (sp_c > 5'sd10) sp_c = 5'sd10;
      if (sp_c < -5'sd10) sp_c = -5'sd10;
      if (sp_c > 5'sd5) begin
         sp_c   = sp_c - 5'sd5;
         both_c = 1'b1;
      end
      if (sp_c < -5'sd5) begin
         sp_c   = sp_c + 5'sd5;
         both_c = 1'b1;
      end
      now_c = 5'(oct_ff);
      hd_c  = 5'(head_ff);
      if (sp_c == 5'sd0) begin
         now_c = 5'sd0;
         hd_c  = 5'sd0;
      end else if (sp_c > 5'sd0) begin
         if (hd_c == 5'sd0) begin
            hd_c = 5'sd1;
         end else begin
            now_c = now_c + hd_c;
            if (now_c > sp_c) begin
               now_c = both_c ? sp_c : 5'sd0;
               hd_c  = both_c ? -5'sd1 : 5'sd1;
            end else if (now_c < 5'sd0) begin
               now_c = 5'sd0;
               hd_c  = 5'sd1;
            end
         end
      end else begin
         if (hd_c == 5'sd0) begin
            hd_c = -5'sd1;
         end else begin
            now_c = now_c + hd_c;
            if (now_c < sp_c) begin
               now_c = both_c ? sp_c : 5'sd0;
               hd_c  = both_c ? 5'sd1 : -5'sd1;
            end else if (now_c > 5'sd0) begin
               now_c = 5'sd0;
               hd_c  = -5'sd1;
            end
         end
      end
   end

   // slot pick from the reduced walk position
   assign n_s     = SW'(total_ff);
   assign s_v     = SW'(s_ff);
   assign h_v     = s_v >>> 1;
   assign rank_s  = SW'(rank_ff);
   assign rmod_s  = SW'(rmod_ff);
   assign below_s = SW'(below_ff);
   always_comb begin
      case (mode_ff) inside
         MODE_ORDER: slot_raw = rank_s;
         MODE_UP, MODE_DOWN: slot_raw = s_v;
         MODE_UPDOWN, MODE_DOWNUP: begin
            if (n_s >= TWO_S) begin
               slot_raw = (s_v < n_s - ONE_S) ? s_v : (n_s + n_s - TWO_S - s_v);
            end else begin
               slot_raw = '0;
            end
         end
         MODE_UPANDDOWN, MODE_DOWNANDUP: begin
            slot_raw = (s_v < n_s) ? s_v : (n_s + n_s - ONE_S - s_v);
         end
         MODE_CONVERGE: slot_raw = s_ff[0] ? (n_s - h_v - ONE_S) : h_v;
         MODE_DIVERGE: slot_raw = (n_s >>> 1) + (s_ff[0] ? (-h_v - ONE_S) : h_v);
         MODE_RANDOM: slot_raw = rmod_s;
         default: slot_raw = '0;
      endcase
      if (mode_ff == MODE_DOWN || mode_ff == MODE_DOWNUP || mode_ff == MODE_DOWNANDUP) begin
         slot_rev = n_s - slot_raw - ONE_S;
      end else begin
         slot_rev = slot_raw;
      end
      slot_c = slot_rev;
      if (slot_c < 0) slot_c = '0;
      if (slot_c > n_s - ONE_S) slot_c = n_s - ONE_S;
      // unknown modes leave the walk position where it was
      s_new = (mode_ff > MODE_RANDOM) ? SW'(wpos_ff) : s_v;
   end

   assign slot_ext  = (IDX_W+4)'(cur_ff);
   assign count_ext = (CNT_W+5)'(total_ff);

   always_comb begin
      mode_in     = mode_ff;
      span_in     = span_ff;
      lock_in     = lock_ff;
      cmd_in      = cmd_ff;
      pitch_in    = pitch_ff;
      rnd_in      = rnd_ff;
      total_in    = total_ff;
      oc_in       = oc_ff;
      wpos_in     = wpos_ff;
      cur_in      = cur_ff;
      oct_in      = oct_ff;
      head_in     = head_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      below_in    = below_ff;
      pos_in      = pos_ff;
      key_in      = key_ff;
      hit_in      = hit_ff;
      posfound_in = posfound_ff;
      s_in        = s_ff;
      rmod_in     = rmod_ff;
      rank_in     = rank_ff;
      vres_in     = vres_ff;
      rpitch_in   = rpitch_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WALK_MODE:    mode_in = csr_data[3:0];
            CSR_OCTAVE_SPAN:  span_in = signed'(csr_data);
            CSR_REMOVAL_LOCK: lock_in = csr_data[0];
            default: ;
         endcase
      end

      if (ctl.accept) begin
         cmd_in   = req_tdata[1:0];
         pitch_in = signed'(req_tdata[9:2]);
         rnd_in   = req_tdata[17:10];
      end

      if (ctl.decode) begin
         idx_in      = '0;
         pos_in      = total_ff;
         hit_in      = 1'b0;
         posfound_in = 1'b0;
         rank_in     = '0;
         vres_in     = 1'b0;
         rpitch_in   = '0;
         if (cmd_ff == CMD_RESTART) begin
            wpos_in = '1;
            cur_in  = '0;
            oct_in  = '0;
            head_in = '0;
            oc_in   = '0;
         end else if (cmd_ff == CMD_ADVANCE && total_ff == '0) begin
            oc_in = '0;
         end
      end

      if (ctl.scan_ev) begin
         if (cmd_ff == CMD_RESTART && rd_order > oc_ff) begin
            oc_in = rd_order + ORDER_W'(1);
         end
         if (rd_pitch == pitch_ff) begin
            hit_in = 1'b1;
            if (cmd_ff == CMD_REMOVE && !hit_ff) pos_in = idx_ff;
         end
         // insertion point: first entry not below the new pitch
         if (cmd_ff == CMD_ADD && !posfound_ff && !(rd_pitch < pitch_ff)) begin
            pos_in      = idx_ff;
            posfound_in = 1'b1;
         end
         idx_in = idx_p1;
      end

      if (ctl.scan_end) begin
         idx_in = (cmd_ff == CMD_ADD) ? total_ff : pos_ff;
      end

      if (ctl.shift_wr) begin
         idx_in = (cmd_ff == CMD_ADD) ? idx_m1 : idx_p1;
      end

      if (ctl.commit) begin
         if (cmd_ff == CMD_ADD) begin
            oc_in    = oc_ff + ORDER_W'(1);
            total_in = total_ff + CNT_W'(1);
         end else begin
            total_in = total_m1;
         end
      end

      if (ctl.mod1_take) s_in = rem_out[SU-1:0];
      if (ctl.mod2_take) rmod_in = rem_out[IDX_W-1:0];

      if (ctl.rk_i_ev) begin
         key_in   = rd_order;
         jdx_in   = '0;
         below_in = '0;
      end
      if (ctl.rk_j_ev) begin
         if (rd_order < key_ff) below_in = below_ff + CNT_W'(1);
         jdx_in = jdx_ff + CNT_W'(1);
      end
      if (ctl.rk_chk) begin
         if (below_s == s_v) rank_in = idx_ff[IDX_W-1:0];
         else idx_in = idx_p1;
      end

      if (ctl.pick) begin
         vres_in = 1'b1;
         cur_in  = slot_c[IDX_W-1:0];
         wpos_in = signed'(s_new[WP_W-1:0]);
         if (s_new == '0) begin
            oct_in  = signed'(now_c[3:0]);
            head_in = signed'(hd_c[1:0]);
         end
      end

      if (ctl.out_ev) rpitch_in = rd_data[PITCH_W-1:0];

      if (ctl.respond) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, count_ext[4:0], oct_ff, (vres_ff ? slot_ext[3:0] : 4'd0),
                         (vres_ff ? rpitch_ff : 8'd0), vres_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UP;
         span_ff      <= '0;
         lock_ff      <= 1'b0;
         total_ff     <= '0;
         oc_ff        <= '0;
         wpos_ff      <= '1;
         cur_ff       <= '0;
         oct_ff       <= '0;
         head_ff      <= '0;
         vres_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         span_ff      <= span_in;
         lock_ff      <= lock_in;
         total_ff     <= total_in;
         oc_ff        <= oc_in;
         wpos_ff      <= wpos_in;
         cur_ff       <= cur_in;
         oct_ff       <= oct_in;
         head_ff      <= head_in;
         vres_ff      <= vres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      pitch_ff    <= pitch_in;
      rnd_ff      <= rnd_in;
      idx_ff      <= idx_in;
      jdx_ff      <= jdx_in;
      below_ff    <= below_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      posfound_ff <= posfound_in;
      s_ff        <= s_in;
      rmod_ff     <= rmod_in;
      rank_ff     <= rank_in;
      rpitch_ff   <= rpitch_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.item_cmd    = cmd_ff;
      stat.total_zero  = (total_ff == '0);
      stat.full        = (total_ff >= CNT_W'(MAX_HELD));
      stat.locked      = lock_ff;
      stat.mode_order  = (mode_ff == MODE_ORDER);
      stat.mode_random = (mode_ff == MODE_RANDOM);
      stat.scan_last   = (idx_ff == total_m1);
      stat.scan_hit    = hit_ff;
      stat.shift_done  = (cmd_ff == CMD_ADD) ? (idx_ff == pos_ff) : (idx_ff == total_m1);
      stat.rem_busy    = rem_busy;
      stat.i_last      = (idx_ff == total_m1);
      stat.j_last      = (jdx_ff == total_m1);
      stat.rank_hit    = (below_s == s_v);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ANW_ASSERT_IMPLIES(a_total_bound, clock, reset, 1'b1, total_ff <= CNT_W'(MAX_HELD))
   `ANW_ASSERT_NEXT(a_pick_in_range, clock, reset, ctl.pick, CNT_W'(cur_ff) < total_ff)
   `ANW_ASSERT_IMPLIES(a_rem_idle_at_start, clock, reset, rem_start, !rem_busy)
   `ANW_ASSERT_IMPLIES(a_scan_in_table, clock, reset, ctl.scan_ev, idx_ff < total_ff)
endmodule

// File: tb/tb.sv
// Self-checking testbench for the arpeggiator note walker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import anw_pkg::*;

   typedef enum int {STIM_ITEM, STIM_CSR, STIM_DRAIN, STIM_HOLD} stim_kind_type;

   typedef struct {
      stim_kind_type    kind;
      logic [1:0]       cmd;
      logic [7:0]       pitch;
      logic [7:0]       rnd;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } stim_type;

   typedef struct {
      logic       note_valid;
      logic [7:0] pitch;
      logic [3:0] slot;
      logic [3:0] octave;
      logic [4:0] count;
   } note_pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   arpeggiator_note_walker u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // note table model
   logic signed [7:0] tbl_pitch [16];
   logic [31:0] tbl_order [16];
   int          tbl_total;
   logic [31:0] arrival;
   int          walk_pos;
   int          cur_slot;
   int          oct_now;
   int          oct_dir;
   logic [3:0]  cfg_mode;
   int          cfg_span;
   logic        cfg_lock;

   stim_type      stim_q[$];
   note_pick_type picks_due[$];
   int  errors = 0;
   int  items_sent = 0;
   int  notes_seen = 0;
   int  csr_writes = 0;
   int  hold_requests = 0;
   bit  calm = 0;

   task automatic flag_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int slot_of_rank(int rank);
      int below;
      for (int i = 0; i < tbl_total; i++) begin
         below = 0;
         for (int j = 0; j < tbl_total; j++)
            if (tbl_order[j] < tbl_order[i]) below++;
         if (below == rank) return i;
      end
      return 0;
   endfunction

   function automatic void step_octave();
      int  span;
      bit  both;
      span = cfg_span;
      both = 0;
      if (span > 10) span = 10;
      if (span < -10) span = -10;
      if (span > 5) begin span -= 5; both = 1; end
      if (span < -5) begin span += 5; both = 1; end
      if (span == 0) begin
         oct_now = 0;
         oct_dir = 0;
      end else if (span > 0) begin
         if (oct_dir == 0) oct_dir = 1;
         else begin
            oct_now += oct_dir;
            if (oct_now > span) begin
               oct_now = both ? span : 0;
               oct_dir = both ? -1 : 1;
            end else if (oct_now < 0) begin
               oct_now = 0;
               oct_dir = 1;
            end
         end
      end else begin
         if (oct_dir == 0) oct_dir = -1;
         else begin
            oct_now += oct_dir;
            if (oct_now < span) begin
               oct_now = both ? span : 0;
               oct_dir = both ? 1 : -1;
            end else if (oct_now > 0) begin
               oct_now = 0;
               oct_dir = -1;
            end
         end
      end
   endfunction

   // Advance one step; returns 0 when no note is held.
   function automatic bit advance_walk(logic [7:0] rnd);
      int n, s, slot, h;
      n = tbl_total;
      s = walk_pos;
      slot = 0;
      if (n == 0) begin
         arrival = '0;
         return 0;
      end
      case (cfg_mode)
         MODE_ORDER: begin
            s = (s + 1) % n;
            slot = slot_of_rank(s);
         end
         MODE_UP, MODE_DOWN: begin
            s = (s + 1) % n;
            slot = s;
         end
         MODE_UPDOWN, MODE_DOWNUP: begin
            if (n >= 2) begin
               s = (s + 1) % ((n - 1) * 2);
               h = s % (n - 1);
               slot = (s < n - 1) ? h : n - h - 1;
            end else s = 0;
         end
         MODE_UPANDDOWN, MODE_DOWNANDUP: begin
            s = (s + 1) % (n * 2);
            h = s % n;
            slot = (s < n) ? h : n - h - 1;
         end
         MODE_CONVERGE: begin
            s = (s + 1) % n;
            slot = s / 2;
            if (s % 2 == 1) slot = n - slot - 1;
         end
         MODE_DIVERGE: begin
            s = (s + 1) % n;
            h = s / 2;
            slot = n / 2 + ((s % 2 == 0) ? h : -h - 1);
         end
         MODE_RANDOM: begin
            s = (s + 1) % n;
            slot = int'(rnd) % n;
         end
         default: ;
      endcase
      if (cfg_mode == MODE_DOWN || cfg_mode == MODE_DOWNUP || cfg_mode == MODE_DOWNANDUP)
         slot = n - slot - 1;
      walk_pos = s;
      if (s == 0) step_octave();
      if (slot < 0) slot = 0;
      if (slot > n - 1) slot = n - 1;
      cur_slot = slot;
      return 1;
   endfunction

   task automatic walk_note_table(logic [1:0] cmd, logic signed [7:0] p, logic [7:0] rnd);
      note_pick_type r;
      bit valid;
      int pos;
      bit skip;
      valid = 0;
      skip = 0;
      case (cmd)
         CMD_RESTART: begin
            walk_pos = -1;
            cur_slot = 0;
            oct_now = 0;
            oct_dir = 0;
            arrival = '0;
            for (int i = 0; i < tbl_total; i++)
               if (tbl_order[i] > arrival) arrival = tbl_order[i] + 32'd1;
         end
         CMD_ADD: begin
            if (tbl_total >= 16) skip = 1;
            for (int i = 0; i < tbl_total; i++)
               if (tbl_pitch[i] == p) skip = 1;
            if (!skip) begin
               pos = 0;
               while (pos < tbl_total && tbl_pitch[pos] < p) pos++;
               for (int i = tbl_total; i > pos; i--) begin
                  tbl_pitch[i] = tbl_pitch[i-1];
                  tbl_order[i] = tbl_order[i-1];
               end
               arrival = arrival + 32'd1;
               tbl_pitch[pos] = p;
               tbl_order[pos] = arrival;
               tbl_total++;
            end
         end
         CMD_REMOVE: begin
            if (!cfg_lock) begin
               pos = -1;
               for (int i = 0; i < tbl_total; i++)
                  if (pos < 0 && tbl_pitch[i] == p) pos = i;
               if (pos >= 0) begin
                  for (int j = pos; j + 1 < tbl_total; j++) begin
                     tbl_pitch[j] = tbl_pitch[j+1];
                     tbl_order[j] = tbl_order[j+1];
                  end
                  tbl_total--;
               end
            end
         end
         default: valid = advance_walk(rnd);
      endcase
      r.note_valid = valid;
      if (valid && cur_slot < tbl_total) begin
         r.pitch = tbl_pitch[cur_slot];
         r.slot = cur_slot[3:0];
      end else begin
         r.pitch = '0;
         r.slot = '0;
      end
      r.octave = oct_now[3:0];
      r.count = tbl_total[4:0];
      picks_due.push_back(r);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // driver
   int tx_gap = 0;
   int settle = 0;
   always @(posedge clock) begin
      logic nv;
      logic [REQ_DATA_W-1:0] nd;
      logic ncv;
      logic [CSR_IDX_W-1:0] nci;
      logic [CSR_DATA_W-1:0] ncd;
      stim_type e;
      nv = req_tvalid;
      nd = req_tdata;
      ncv = 1'b0;
      nci = csr_index;
      ncd = csr_data;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            walk_note_table(req_tdata[1:0], req_tdata[9:2], req_tdata[17:10]);
            items_sent++;
            nv = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_WALK_MODE:    cfg_mode = csr_data[3:0];
               CSR_OCTAVE_SPAN:  cfg_span = int'($signed(csr_data));
               CSR_REMOVAL_LOCK: cfg_lock = csr_data[0];
               default: ;
            endcase
         end
         if (!nv) begin
            if (tx_gap > 0) tx_gap--;
            else if (stim_q.size() > 0) begin
               e = stim_q[0];
               case (e.kind)
                  STIM_ITEM: begin
                     nv = 1'b1;
                     nd = {6'b0, e.rnd, e.pitch, e.cmd};
                     void'(stim_q.pop_front());
                     tx_gap = pick_gap();
                  end
                  STIM_CSR: begin
                     // write only once the block has gone quiet
                     if (picks_due.size() == 0) begin
                        if (settle >= 20) begin
                           ncv = 1'b1;
                           nci = e.idx;
                           ncd = e.data;
                           settle = 0;
                           void'(stim_q.pop_front());
                        end else settle++;
                     end else settle = 0;
                  end
                  STIM_DRAIN: if (picks_due.size() == 0) void'(stim_q.pop_front());
                  default: begin
                     hold_requests++;
                     void'(stim_q.pop_front());
                  end
               endcase
            end
         end
      end
      req_tvalid <= nv;
      req_tdata <= nd;
      csr_valid <= ncv;
      csr_index <= nci;
      csr_data <= ncd;
   end

   // monitor
   int hold_served = 0;
   int hold_left = 0;
   int rx_gap = 0;
   always @(posedge clock) begin
      note_pick_type want;
      logic rdy;
      rdy = 1'b1;
      if (reset) begin
         rdy = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (picks_due.size() == 0) begin
               $display("unexpected result item %h at %0t", rsp_tdata, $realtime);
               errors++;
            end else begin
               want = picks_due.pop_front();
               if (rsp_tdata[0] !== want.note_valid)
                  flag_mismatch("note_valid", rsp_tdata[0], want.note_valid);
               if (rsp_tdata[8:1] !== want.pitch)
                  flag_mismatch("chosen_pitch", $signed(rsp_tdata[8:1]), $signed(want.pitch));
               if (rsp_tdata[12:9] !== want.slot)
                  flag_mismatch("chosen_slot", rsp_tdata[12:9], want.slot);
               if (rsp_tdata[16:13] !== want.octave)
                  flag_mismatch("octave_shift", $signed(rsp_tdata[16:13]),
                                $signed(want.octave));
               if (rsp_tdata[21:17] !== want.count)
                  flag_mismatch("held_count", rsp_tdata[21:17], want.count);
               if (rsp_tdata[0]) notes_seen++;
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rdy = 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rx_gap = pick_gap();
            rdy = (rx_gap == 0);
         end
      end
      rsp_tready <= rdy;
   end

   task automatic queue_item(logic [1:0] cmd, logic [7:0] pitch, logic [7:0] rnd);
      stim_type e;
      e.kind = STIM_ITEM;
      e.cmd = cmd;
      e.pitch = pitch;
      e.rnd = rnd;
      e.idx = '0;
      e.data = '0;
      stim_q.push_back(e);
   endtask

   task automatic queue_marker(stim_kind_type kind, logic [CSR_IDX_W-1:0] idx,
                               logic [CSR_DATA_W-1:0] data);
      stim_type e;
      e.kind = kind;
      e.cmd = CMD_RESTART;
      e.pitch = '0;
      e.rnd = '0;
      e.idx = idx;
      e.data = data;
      stim_q.push_back(e);
   endtask

   task automatic queue_random_item();
      int roll;
      logic [1:0] cmd;
      logic [7:0] pitch;
      roll = $urandom_range(99);
      if (roll < 35) cmd = CMD_ADD;
      else if (roll < 52) cmd = CMD_REMOVE;
      else if (roll < 95) cmd = CMD_ADVANCE;
      else cmd = CMD_RESTART;
      // a small pitch pool makes duplicates and hits on remove common
      if ($urandom_range(99) < 70) pitch = 8'($signed($urandom_range(16)) - 8);
      else pitch = 8'($urandom);
      queue_item(cmd, pitch, 8'($urandom));
   endtask

   initial begin
      logic [4:0] spans [6];
      spans = '{5'd0, 5'd10, 5'b10110, 5'd15, 5'b10000, 5'd5};
      walk_pos = -1;
      cur_slot = 0;
      oct_now = 0;
      oct_dir = 0;
      tbl_total = 0;
      arrival = '0;
      cfg_mode = MODE_UP;
      cfg_span = 0;
      cfg_lock = 1'b0;

      // directed: extremes, duplicates, empty advance, full table, lock
      calm = 1;
      queue_item(CMD_ADVANCE, 8'h00, 8'hFF);
      queue_item(CMD_ADD, 8'h80, 8'h00);
      queue_item(CMD_ADD, 8'h7F, 8'hFF);
      queue_item(CMD_ADD, 8'h7F, 8'h00);
      queue_item(CMD_ADVANCE, 8'h00, 8'h00);
      queue_item(CMD_ADVANCE, 8'h00, 8'h00);
      queue_item(CMD_REMOVE, 8'h05, 8'h00);
      queue_item(CMD_RESTART, 8'hFF, 8'hFF);
      for (int i = 0; i < 15; i++) queue_item(CMD_ADD, 8'(i * 3 - 20), 8'h00);
      queue_item(CMD_ADVANCE, 8'h00, 8'h00);
      queue_marker(STIM_CSR, CSR_REMOVAL_LOCK, 5'd1);
      queue_item(CMD_REMOVE, 8'h80, 8'h00);
      queue_marker(STIM_CSR, CSR_REMOVAL_LOCK, 5'd0);
      queue_item(CMD_REMOVE, 8'h80, 8'h00);
      queue_marker(STIM_DRAIN, '0, '0);

      // random phases, each with fresh register settings
      for (int ph = 0; ph < 16; ph++) begin
         queue_marker(STIM_CSR, CSR_WALK_MODE,
                      (ph < 10) ? 5'(ph) : 5'($urandom_range(15)));
         queue_marker(STIM_CSR, CSR_OCTAVE_SPAN,
                      (ph < 6) ? spans[ph] : 5'($urandom));
         queue_marker(STIM_CSR, CSR_REMOVAL_LOCK, 5'($urandom_range(3) == 0));
         if (ph % 4 == 2) queue_item(CMD_RESTART, 8'($urandom), 8'($urandom));
         for (int k = 0; k < 42; k++) begin
            queue_random_item();
            if (ph == 5 && k == 10) queue_marker(STIM_HOLD, '0, '0);
            if (ph == 9 && k == 20) queue_marker(STIM_DRAIN, '0, '0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (60) @(posedge clock);
      calm = 0;
      while (stim_q.size() > 0 || req_tvalid) @(posedge clock);
      while (picks_due.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("tb: %0d command items, %0d picked notes, %0d register writes",
               items_sent, notes_seen, csr_writes);
      $display("tb: all walk modes, octave spans and lock settings exercised");
      if (errors == 0 && picks_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb: errors");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/anw_pkg.sv
rtl/anw_ram.sv
rtl/anw_rem.sv
rtl/anw_ctrl.sv
rtl/anw_datapath.sv
rtl/arpeggiator_note_walker.sv
tb/tb.sv
